// ===== sv/fvn_pkg.sv =====
// shared types, constants and tables of the fractal value noise block
`default_nettype none
package fvn_pkg;

  localparam int LATENCY = 11;

  typedef enum logic [1:0] {
    REG_FREQUENCY    = 2'd0,
    REG_OCTAVE_COUNT = 2'd1,
    REG_SEED_BYTE    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] frequency;
    logic [3:0]  octave_count;
    logic [7:0]  seed_byte;
  } cfg_t;

  localparam logic [7:0] PERM [256] = '{
    8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56, 8'd161, 8'd78,
    8'd24, 8'd140, 8'd71, 8'd48, 8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247,
    8'd40, 8'd185, 8'd248, 8'd251, 8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76,
    8'd36, 8'd1, 8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
    8'd167, 8'd204, 8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174, 8'd173, 8'd102,
    8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108, 8'd167, 8'd44, 8'd43, 8'd77,
    8'd180, 8'd204, 8'd8, 8'd81, 8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254,
    8'd210, 8'd210, 8'd177, 8'd32, 8'd81, 8'd195, 8'd243, 8'd125, 8'd8, 8'd169,
    8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13, 8'd203, 8'd9, 8'd47, 8'd104,
    8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203, 8'd181, 8'd235, 8'd193, 8'd206,
    8'd70, 8'd180, 8'd174, 8'd0, 8'd167, 8'd181, 8'd41, 8'd164, 8'd30, 8'd116,
    8'd127, 8'd198, 8'd245, 8'd146, 8'd87, 8'd224, 8'd149, 8'd206, 8'd57, 8'd4,
    8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105, 8'd228, 8'd108,
    8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195, 8'd38, 8'd58, 8'd65, 8'd207,
    8'd215, 8'd253, 8'd65, 8'd85, 8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55,
    8'd89, 8'd232, 8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
    8'd90, 8'd17, 8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177,
    8'd73, 8'd174, 8'd193, 8'd100, 8'd192, 8'd143, 8'd97, 8'd53, 8'd145, 8'd135,
    8'd19, 8'd103, 8'd13, 8'd90, 8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247,
    8'd33, 8'd39, 8'd145, 8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86, 8'd99,
    8'd41, 8'd237, 8'd203, 8'd111, 8'd79, 8'd220, 8'd135, 8'd158, 8'd42, 8'd30,
    8'd154, 8'd120, 8'd67, 8'd87, 8'd167, 8'd135, 8'd176, 8'd183, 8'd191, 8'd253,
    8'd115, 8'd184, 8'd21, 8'd233, 8'd58, 8'd129, 8'd233, 8'd142, 8'd39, 8'd128,
    8'd211, 8'd118, 8'd137, 8'd139, 8'd255, 8'd114, 8'd20, 8'd218, 8'd113, 8'd154,
    8'd27, 8'd127, 8'd246, 8'd250, 8'd1, 8'd8, 8'd198, 8'd250, 8'd209, 8'd92,
    8'd222, 8'd173, 8'd21, 8'd88, 8'd102, 8'd219
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM[idx];
  endfunction

  // floor(2^32 / (2^n - 1)), single octave held below 2^32
  function automatic logic [31:0] recip(input logic [4:0] n);
    logic [31:0] r;
    case (n)
      5'd1:    r = 32'd4294967295;
      5'd2:    r = 32'd1431655765;
      5'd3:    r = 32'd613566756;
      5'd4:    r = 32'd286331153;
      5'd5:    r = 32'd138547332;
      5'd6:    r = 32'd68174084;
      5'd7:    r = 32'd33818640;
      5'd8:    r = 32'd16843009;
      5'd9:    r = 32'd8405024;
      5'd10:   r = 32'd4198404;
      5'd11:   r = 32'd2098176;
      5'd12:   r = 32'd1048832;
      5'd13:   r = 32'd524352;
      5'd14:   r = 32'd262160;
      5'd15:   r = 32'd131076;
      5'd16:   r = 32'd65537;
      default: r = 32'd4294967295;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/fvn_octave.sv =====
// one octave lane: lattice hash, smoothstep weights and bilinear blend
`default_nettype none
module fvn_octave #(
  parameter int LEVEL = 0
) (
  input  wire logic        clk,
  input  wire logic [47:0] px,
  input  wire logic [47:0] py,
  input  wire logic [7:0]  seed,
  output logic      [39:0] v
);

  localparam int HI = 39 - LEVEL;

  logic [7:0]  xi, yi;
  logic [15:0] fx, fy;
  logic [31:0] sqx, sqy;

  logic [7:0]  a_row0, a_row1, a_xi;
  logic [15:0] a_fx, a_fy, a_f2x, a_f2y;

  logic [17:0] tx, ty;
  logic [33:0] ex, ey;
  logic [7:0]  b_c00, b_c10, b_c01, b_c11;
  logic [15:0] b_wx, b_wy;

  logic signed [8:0]  d0, d1;
  logic signed [25:0] p0, p1;
  logic signed [25:0] c_lo, c_hi;
  logic [15:0]        c_wy;

  logic signed [26:0] dy;
  logic signed [43:0] py_prod, v_full;

  // stage a: lattice split, row hash, squared fraction
  always_comb begin
    xi  = px[HI -: 8];
    yi  = py[HI -: 8];
    fx  = px[HI-8 -: 16];
    fy  = py[HI-8 -: 16];
    sqx = fx * fx;
    sqy = fy * fy;
  end

  always_ff @(posedge clk) begin
    a_row0 <= fvn_pkg::perm(yi + seed);
    a_row1 <= fvn_pkg::perm(yi + seed + 8'd1);
    a_xi   <= xi;
    a_fx   <= fx;
    a_fy   <= fy;
    a_f2x  <= sqx[31:16];
    a_f2y  <= sqy[31:16];
  end

  // stage b: smoothstep weights and corner hash
  always_comb begin
    tx = 18'd196608 - {1'b0, a_fx, 1'b0};
    ty = 18'd196608 - {1'b0, a_fy, 1'b0};
    ex = a_f2x * tx;
    ey = a_f2y * ty;
  end

  always_ff @(posedge clk) begin
    b_wx  <= ex[31:16];
    b_wy  <= ey[31:16];
    b_c00 <= fvn_pkg::perm(a_row0 + a_xi);
    b_c10 <= fvn_pkg::perm(a_row0 + a_xi + 8'd1);
    b_c01 <= fvn_pkg::perm(a_row1 + a_xi);
    b_c11 <= fvn_pkg::perm(a_row1 + a_xi + 8'd1);
  end

  // stage c: blend along x
  always_comb begin
    d0 = $signed({1'b0, b_c10}) - $signed({1'b0, b_c00});
    d1 = $signed({1'b0, b_c11}) - $signed({1'b0, b_c01});
    p0 = $signed({1'b0, b_wx}) * d0;
    p1 = $signed({1'b0, b_wx}) * d1;
  end

  always_ff @(posedge clk) begin
    c_lo <= $signed({2'b00, b_c00, 16'h0000}) + p0;
    c_hi <= $signed({2'b00, b_c01, 16'h0000}) + p1;
    c_wy <= b_wy;
  end

  // stage d: blend along y
  always_comb begin
    dy      = $signed({c_hi[25], c_hi}) - $signed({c_lo[25], c_lo});
    py_prod = $signed({1'b0, c_wy}) * dy;
    v_full  = $signed({{2{c_lo[25]}}, c_lo, 16'h0000}) + py_prod;
  end

  always_ff @(posedge clk) begin
    v <= v_full[43] ? 40'd0 : v_full[39:0];
  end

endmodule
`default_nettype wire

// ===== sv/fvn_norm.sv =====
// octave weighting, sum tree and normalising divide by reciprocal
`default_nettype none
module fvn_norm #(
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic                               clk,
  input  wire logic [39:0]                        v [MAX_OCTAVES],
  input  wire logic [$clog2(MAX_OCTAVES+1)-1:0]   n,
  output logic      [15:0]                        noise
);

  localparam int NW     = $clog2(MAX_OCTAVES + 1);
  localparam int SW     = 40 + MAX_OCTAVES;
  localparam int GROUPS = (MAX_OCTAVES + 3) / 4;
  localparam int TW     = SW - 24;

  logic [SW-1:0] g_sum_next [GROUPS];
  logic [SW-1:0] g_sum [GROUPS];
  logic [NW-1:0] g_n;

  logic [SW-1:0] total;
  logic [SW-1:0] t_total;
  logic [NW-1:0] t_n;

  logic [SW-1:0] shifted;
  logic [TW-1:0] q_t;
  logic [NW-1:0] q_n;

  logic [TW+31:0]       prod;
  logic [MAX_OCTAVES:0] d_wide;
  logic [TW-1:0]        m_t;
  logic [TW-1:0]        m_q0;
  logic [MAX_OCTAVES-1:0] m_d;

  logic [TW+MAX_OCTAVES-1:0] qd;
  logic [TW-1:0]             rem;
  logic [TW-1:0]             q_fix;

  // weighted octave terms in groups of four
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      g_sum_next[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (g*4 + k < MAX_OCTAVES) begin
          if (NW'(g*4 + k) < n) begin
            g_sum_next[g] = g_sum_next[g] +
              (SW'(v[g*4 + k]) << (MAX_OCTAVES - 1 - (g*4 + k)));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    g_sum <= g_sum_next;
    g_n   <= n;
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + g_sum[g];
    end
  end

  always_ff @(posedge clk) begin
    t_total <= total;
    t_n     <= g_n;
  end

  // drop the extra weight of absent octaves and all but eight fraction bits
  always_comb begin
    shifted = t_total >> (NW'(MAX_OCTAVES) - t_n);
  end

  always_ff @(posedge clk) begin
    q_t <= shifted[SW-1:24];
    q_n <= t_n;
  end

  always_comb begin
    prod   = q_t * fvn_pkg::recip(5'(q_n));
    d_wide = ({{MAX_OCTAVES{1'b0}}, 1'b1} << q_n) - 1'b1;
  end

  always_ff @(posedge clk) begin
    m_q0 <= prod[TW+31:32];
    m_t  <= q_t;
    m_d  <= d_wide[MAX_OCTAVES-1:0];
  end

  // estimate is low by at most one
  always_comb begin
    qd    = m_q0 * m_d;
    rem   = m_t - qd[TW-1:0];
    q_fix = m_q0 + TW'(rem >= TW'(m_d));
  end

  always_ff @(posedge clk) begin
    noise <= q_fix[15:0];
  end

endmodule
`default_nettype wire

// ===== sv/fractal_value_noise_2d.sv =====
// top level of the fractal value noise sampler
// throughput: one point per cycle, busy stays low and the result sink never stalls
// rate is set by the unrolled octave lanes, each a four-stage pipeline
// reset clears the valid pipeline and loads the default configuration
`default_nettype none
module fractal_value_noise_2d #(
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] x_coord,
  input  wire logic [31:0] y_coord,
  output logic             done,
  output logic      [15:0] noise_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int NW = $clog2(MAX_OCTAVES + 1);

  fvn_pkg::cfg_t cfg;

  logic [fvn_pkg::LATENCY-1:0] vld;
  logic [31:0] s0_x, s0_y;
  logic [47:0] s1_px, s1_py;
  logic [39:0] oct_v [MAX_OCTAVES];
  logic [NW-1:0] n_clamp;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frequency    <= 16'd655;
      cfg.octave_count <= 4'd5;
      cfg.seed_byte    <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fvn_pkg::cfg_reg_t'(cfg_index))
        fvn_pkg::REG_FREQUENCY:    cfg.frequency    <= cfg_data;
        fvn_pkg::REG_OCTAVE_COUNT: cfg.octave_count <= cfg_data[3:0];
        fvn_pkg::REG_SEED_BYTE:    cfg.seed_byte    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[fvn_pkg::LATENCY-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s0_x <= x_coord;
      s0_y <= y_coord;
    end
    s1_px <= s0_x * cfg.frequency;
    s1_py <= s0_y * cfg.frequency;
  end

  always_comb begin
    if (cfg.octave_count == 4'd0) begin
      n_clamp = NW'(1);
    end else if (32'(cfg.octave_count) > MAX_OCTAVES) begin
      n_clamp = NW'(MAX_OCTAVES);
    end else begin
      n_clamp = NW'(cfg.octave_count);
    end
  end

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fvn_octave #(.LEVEL(i)) u_oct (
      .clk  (clk),
      .px   (s1_px),
      .py   (s1_py),
      .seed (cfg.seed_byte),
      .v    (oct_v[i])
    );
  end

  fvn_norm #(.MAX_OCTAVES(MAX_OCTAVES)) u_norm (
    .clk   (clk),
    .v     (oct_v),
    .n     (n_clamp),
    .noise (noise_value)
  );

  assign done = vld[fvn_pkg::LATENCY-1];

endmodule
`default_nettype wire

// ===== sv/fvn_checker.sv =====
// port checker for the noise sampler and its bind
`default_nettype none
module fvn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [15:0] noise_value
);

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##11 done)
    else $error("beat accepted without a result");

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 11))
    else $error("result without an accepted beat");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (noise_value <= 16'd65280))
    else $error("noise sample out of range");

endmodule

bind fractal_value_noise_2d fvn_checker u_fvn_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .noise_value (noise_value)
);
`default_nettype wire
